[sv/hsd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsd_pkg: shared types and constants for the distinct-value finder
// Element payload types, register map, key helpers.
// ----------------------------------------------------------------------------
package hsd_pkg;

    localparam int unsigned DefTableSlots = 1024;
    localparam int unsigned CountW        = 11;

    // Element kinds
    localparam logic [1:0] KIND_INT = 2'd0;
    localparam logic [1:0] KIND_C64 = 2'd1;
    localparam logic [1:0] KIND_C128 = 2'd2;

    // Register indexes
    localparam logic [0:0] REG_KIND = 1'b0;
    localparam logic [0:0] REG_NAN  = 1'b1;

    localparam logic [63:0] HASH_MUL = 64'hff51afd7ed558ccd;

    typedef struct packed {
        logic [63:0] value_low;
        logic [63:0] value_high;
        logic        is_last;
    } t_in_item;

    typedef struct packed {
        logic              first_seen;
        logic [63:0]       unique_low;
        logic [63:0]       unique_high;
        logic [CountW-1:0] distinct_count;
        logic              table_full;
        logic              end_of_array;
    } t_out_item;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;      // capture input item, form key
        logic hash_mul;  // register hash product
        logic start;     // set probe position, issue first read
        logic step;      // advance probe position, issue read
        logic insert;    // write key into current slot
        logic finish;    // build result
        logic clr_step;  // clear next valid bit
    } t_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic slot_empty;  // probed slot not valid
        logic slot_match;  // probed slot matches
        logic probes_done; // all slots visited
        logic clr_done;    // clearing at last entry
        logic last;        // item marks end of array
    } t_sts;

    function automatic logic f32_nan(input logic [31:0] x);
        return x[30:0] > 31'h7F800000;
    endfunction

    function automatic logic f64_nan(input logic [63:0] x);
        return x[62:0] > 63'h7FF0000000000000;
    endfunction

    function automatic logic key_nan(input logic [1:0] k, input logic [127:0] key);
        logic r;
        r = 1'b0;
        case (k)
            KIND_C64:  r = f32_nan(key[31:0]) || f32_nan(key[63:32]);
            KIND_C128: r = f64_nan(key[63:0]) || f64_nan(key[127:64]);
            default:   r = 1'b0;
        endcase
        return r;
    endfunction

endpackage

[sv/hsd_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsd_ram: generic single-port RAM
// One address per cycle: read every cycle, write when i_we; registered read data.
// ----------------------------------------------------------------------------
module hsd_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;
endmodule

[sv/hsd_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsd_datapath: key forming, hashing, probing and result building
// Holds the key RAM, the slot valid bits, the count and the result register.
// ----------------------------------------------------------------------------
module hsd_datapath #(
    parameter int unsigned TABLE_SLOTS = hsd_pkg::DefTableSlots
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [1:0]       i_kind,
    input  logic             i_nan_equal,
    input  hsd_pkg::t_in_item i_item,
    input  hsd_pkg::t_cmd    i_cmd,
    output hsd_pkg::t_sts    o_sts,
    output hsd_pkg::t_out_item o_result
);
    import hsd_pkg::*;

    localparam int unsigned AW = $clog2(TABLE_SLOTS);

    logic [1:0]        w_kind;
    logic [127:0]      w_key;
    logic [63:0]       w_h0;
    t_in_item          r_item;
    logic [127:0]      r_key;
    logic              r_nan;
    logic [63:0]       r_h;
    logic [63:0]       r_plo;
    logic [31:0]       r_cross;
    logic [63:0]       w_p0;
    logic [31:0]       w_c0;
    logic [31:0]       w_c1;
    logic [63:0]       w_h;
    logic [AW-1:0]     r_pos;
    logic [AW-1:0]     n_pos;
    logic [AW:0]       r_probes;
    logic [AW-1:0]     r_clr;
    logic [CountW-1:0] r_count;
    t_out_item         r_result;
    logic [128:0]      w_rdata;
    logic [128:0]      w_wdata;
    logic              w_slot_valid;
    logic [63:0]       w_hm;
    logic              w_stored_nan;
    logic              w_match;
    logic              w_full;

    assign w_kind = (i_kind == KIND_C64 || i_kind == KIND_C128) ? i_kind : KIND_INT;

    // Canonical key: zero parts of complex kinds become +0
    always_comb begin
        case (w_kind)
            KIND_C64: begin
                w_key = 128'd0;
                w_key[31:0]  = (i_item.value_low[30:0] == 31'd0) ? 32'd0
                             : i_item.value_low[31:0];
                w_key[63:32] = (i_item.value_low[62:32] == 31'd0) ? 32'd0
                             : i_item.value_low[63:32];
            end
            KIND_C128: begin
                w_key[63:0]   = (i_item.value_low[62:0] == 63'd0) ? 64'd0
                              : i_item.value_low;
                w_key[127:64] = (i_item.value_high[62:0] == 63'd0) ? 64'd0
                              : i_item.value_high;
            end
            default: w_key = {64'd0, i_item.value_low};
        endcase
    end

    // First hash mix: lo ^ rotl(hi,32), then xor-shift
    always_comb begin
        w_h0 = w_key[63:0] ^ {w_key[95:64], w_key[127:96]};
        w_h0 = w_h0 ^ (w_h0 >> 33);
    end

    // Hash multiply from 32-bit partial products; high cross terms drop out
    assign w_p0 = r_h[31:0] * HASH_MUL[31:0];
    assign w_c0 = r_h[31:0] * HASH_MUL[63:32];
    assign w_c1 = r_h[63:32] * HASH_MUL[31:0];
    assign w_h  = r_plo + {r_cross, 32'd0};
    assign w_hm = w_h ^ (w_h >> 33);

    always_comb begin
        n_pos = r_pos + AW'(1);
    end

    // Key RAM with valid bit on top: write on insert or clear, read at probe
    logic [AW-1:0] w_addr;
    assign w_addr = i_cmd.clr_step ? r_clr
                  : i_cmd.start ? (r_nan ? AW'(0) : w_hm[AW-1:0])
                  : i_cmd.step ? n_pos : r_pos;
    assign w_wdata = i_cmd.clr_step ? 129'd0 : {1'b1, r_key};

    hsd_ram #(.WIDTH(129), .DEPTH(TABLE_SLOTS)) u_keys (
        .i_clk   (i_clk),
        .i_we    (i_cmd.insert || i_cmd.clr_step),
        .i_addr  (w_addr),
        .i_wdata (w_wdata),
        .o_rdata (w_rdata)
    );

    assign w_slot_valid = w_rdata[128];
    assign w_stored_nan = key_nan(w_kind, w_rdata[127:0]);
    always_comb begin
        if (r_nan && w_stored_nan) begin
            w_match = i_nan_equal;
        end else if (r_nan || w_stored_nan) begin
            w_match = 1'b0;
        end else begin
            w_match = (w_rdata[127:0] == r_key);
        end
    end

    // Full: last slot of the lap is used and does not match
    assign w_full = w_slot_valid && !w_match && o_sts.probes_done;

    // Item, key and hash registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item <= i_item;
            r_key  <= w_key;
            r_nan  <= key_nan(w_kind, w_key);
            r_h    <= w_h0;
        end
        if (i_cmd.hash_mul) begin
            r_plo   <= w_p0;
            r_cross <= w_c0 + w_c1;
        end
    end

    // Probe position, probe count, clear pointer, count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count       <= '0;
            r_probes      <= '0;
            r_clr         <= '0;
            r_pos         <= '0;
        end else begin
            if (i_cmd.start) begin
                r_pos         <= w_addr;
                r_probes      <= '0;
            end
            if (i_cmd.step) begin
                r_pos         <= n_pos;
                r_probes      <= r_probes + (AW+1)'(1);
            end
            if (i_cmd.insert) begin
                r_count        <= r_count + CountW'(1);
            end
            if (i_cmd.clr_step) begin
                r_clr          <= r_clr + AW'(1);
                r_count        <= '0;
            end
        end
    end

    // Result register; first_seen and full fixed when the result is built
    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_result.first_seen     <= !(w_slot_valid && w_match);
            r_result.unique_low     <= r_item.value_low;
            r_result.unique_high    <= r_item.value_high;
            r_result.distinct_count <= r_count + CountW'(i_cmd.insert);
            r_result.table_full     <= w_full;
            r_result.end_of_array   <= r_item.is_last;
        end
    end

    // probes_done: the last slot of a full lap is being looked at
    assign o_sts.slot_empty  = !w_slot_valid;
    assign o_sts.slot_match  = w_slot_valid && w_match;
    assign o_sts.probes_done = (r_probes == (AW+1)'(TABLE_SLOTS - 1));
    assign o_sts.clr_done    = (r_clr == AW'(TABLE_SLOTS - 1));
    assign o_sts.last        = r_item.is_last;
    assign o_result          = r_result;
endmodule

[sv/hsd_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsd_ctrl: sequencer for one item
// Load, hash, probe until empty/match/lap, insert, hand off, clear at end.
// ----------------------------------------------------------------------------
module hsd_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    input  hsd_pkg::t_sts i_sts,
    output hsd_pkg::t_cmd o_cmd
);
    import hsd_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_MUL   = 7'b0000010,
        S_START = 7'b0000100,
        S_WAIT  = 7'b0001000,
        S_PROBE = 7'b0010000,
        S_OUT   = 7'b0100000,
        S_CLR   = 7'b1000000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_accept;
    logic   w_out_free;

    assign w_out_free = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != S_IDLE);
    assign w_accept   = i_in_valid && (r_state == S_IDLE);

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.hash_mul = 1'b1;
                n_state        = S_START;
            end
            S_START: begin
                o_cmd.start = 1'b1;
                n_state     = S_WAIT;
            end
            S_WAIT: begin
                n_state = S_PROBE;
            end
            S_PROBE: begin
                if (i_sts.slot_empty || i_sts.slot_match || i_sts.probes_done) begin
                    if (w_out_free) begin
                        o_cmd.finish = 1'b1;
                        o_cmd.insert = i_sts.slot_empty;
                        n_out_valid  = 1'b1;
                        n_state      = i_sts.last ? S_CLR : S_IDLE;
                    end
                end else begin
                    o_cmd.step = 1'b1;
                    n_state    = S_WAIT;
                end
            end
            S_CLR: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.clr_done) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Reset starts with a clearing pass over the table
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;
endmodule

[sv/hash_set_distinct_numeric.sv]
`timescale 1ns / 1ps
// From accept, an item passes the load, hash-multiply, start, wait and probe states;
//   each extra probe adds a wait state for the key RAM read and a probe state. A new
//   item is taken only in idle, a stalled result holds the probe state, and the item
//   marking end of array adds a clearing pass. TABLE_SLOTS must be a power of two; the block does not check it.
// Reset (synchronous, active low) sets element_kind=0, nan_equal=1 and the count
//   to zero, then a clearing pass over all TABLE_SLOTS entries empties the table.
// ----------------------------------------------------------------------------
// hash_set_distinct_numeric: streaming distinct-value finder
// Hashed open-addressed table with linear probing; one result per item.
// ----------------------------------------------------------------------------
module hash_set_distinct_numeric #(
    parameter int unsigned TABLE_SLOTS = hsd_pkg::DefTableSlots
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  hsd_pkg::t_in_item   i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output hsd_pkg::t_out_item  o_out_item,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:2]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import hsd_pkg::*;

    logic [1:0] r_kind;
    logic       r_nan_equal;
    t_cmd       w_cmd;
    t_sts       w_sts;

    // Configuration registers
    assign pready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind      <= KIND_INT;
            r_nan_equal <= 1'b1;
        end else if (psel && penable && pwrite) begin
            case (paddr[2])
                REG_KIND: r_kind      <= pwdata[1:0];
                REG_NAN:  r_nan_equal <= pwdata[0];
                default:  ;
            endcase
        end
    end
    assign prdata = (paddr[2] == REG_NAN) ? {31'd0, r_nan_equal} : {30'd0, r_kind};

    hsd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    hsd_datapath #(.TABLE_SLOTS(TABLE_SLOTS)) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_kind      (r_kind),
        .i_nan_equal (r_nan_equal),
        .i_item      (i_in_item),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_result    (o_out_item)
    );

    // Insert only when the probe landed on an empty slot
    a_insert_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.insert |-> w_sts.slot_empty) else $error("insert on used slot");
    // A new result is only built when the output register is free
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |-> !w_cmd.finish) else $error("result lost");
    // No item taken while the table is being cleared
    a_accept_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.clr_step |-> o_in_stall) else $error("accept during clear");
endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: distinct-value finder check
// Feeds arrays of integer and complex elements through the stream port under
// bursty input and random output stalls, predicts every result with a local
// hashed-table model and compares field by field. Covers signed zeros, NaNs
// with both NaN policies, the unused kind code and a completely filled table.
// ----------------------------------------------------------------------------
module testbench;
    import hsd_pkg::*;

    localparam int unsigned Slots      = DefTableSlots;
    localparam logic [1:0]  KIND_RSVD  = 2'd3;
    localparam int unsigned CycleLimit = 3000000;
    localparam int unsigned ClearWait  = 1200;
    localparam int unsigned LongHold   = 3000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    t_in_item    in_item = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    t_out_item   out_item;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:2]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    hash_set_distinct_numeric dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Model state and register shadow
    bit           slot_used [Slots];
    logic [127:0] slot_key [Slots];
    int unsigned  live_count;
    logic [1:0]   cfg_kind = KIND_INT;
    logic         cfg_nan_eq = 1'b1;

    t_in_item    feed_q [$];
    t_out_item   result_q [$];
    int unsigned errors = 0;
    int unsigned items_seen = 0;
    int unsigned firsts_seen = 0;
    int unsigned fulls_seen = 0;
    int unsigned cycles = 0;
    bit          sender_gaps = 1'b1;
    bit          long_hold_req = 1'b0;
    bit          long_hold_done = 1'b0;

    function automatic logic [1:0] eff_kind();
        return (cfg_kind == KIND_C64 || cfg_kind == KIND_C128) ? cfg_kind : KIND_INT;
    endfunction

    function automatic bit nan32(input logic [31:0] x);
        return x[30:23] == 8'hFF && x[22:0] != 0;
    endfunction

    function automatic bit nan64(input logic [63:0] x);
        return x[62:52] == 11'h7FF && x[51:0] != 0;
    endfunction

    function automatic bit key_nan_now(input logic [127:0] key);
        case (eff_kind())
            KIND_C64:  return nan32(key[31:0]) || nan32(key[63:32]);
            KIND_C128: return nan64(key[63:0]) || nan64(key[127:64]);
            default:   return 1'b0;
        endcase
    endfunction

    function automatic bit keys_equal(input logic [127:0] a, input logic [127:0] b);
        bit an;
        bit bn;
        an = key_nan_now(a);
        bn = key_nan_now(b);
        if (an && bn) return cfg_nan_eq;
        if (an || bn) return 1'b0;
        return a == b;
    endfunction

    // Look up one element, insert if new, return the result it should give
    function automatic t_out_item dedup_result(input t_in_item it);
        logic [127:0] key;
        logic [63:0]  h;
        logic [31:0]  re32;
        logic [31:0]  im32;
        int unsigned  pos;
        bit           found;
        bit           full;
        t_out_item    r;
        found = 1'b0;
        full  = 1'b1;
        re32 = it.value_low[31:0];
        im32 = it.value_low[63:32];
        case (eff_kind())
            KIND_C64: begin
                if (re32[30:0] == 0) re32 = '0;
                if (im32[30:0] == 0) im32 = '0;
                key = {64'd0, im32, re32};
            end
            KIND_C128: begin
                key = {it.value_high, it.value_low};
                if (key[126:64] == 0) key[127:64] = '0;
                if (key[62:0] == 0) key[63:0] = '0;
            end
            default: key = {64'd0, it.value_low};
        endcase
        if (key_nan_now(key)) begin
            pos = 0;
        end else begin
            h = key[63:0] ^ {key[95:64], key[127:96]};
            h = h ^ (h >> 33);
            h = h * HASH_MUL;
            h = h ^ (h >> 33);
            pos = h % Slots;
        end
        for (int n = 0; n < Slots; n++) begin
            if (!slot_used[pos]) begin
                full = 1'b0;
                break;
            end
            if (keys_equal(key, slot_key[pos])) begin
                found = 1'b1;
                full = 1'b0;
                break;
            end
            pos = (pos + 1) % Slots;
        end
        if (!found && !full) begin
            slot_used[pos] = 1'b1;
            slot_key[pos]  = key;
            live_count++;
        end
        r.first_seen     = !found;
        r.unique_low     = it.value_low;
        r.unique_high    = it.value_high;
        r.distinct_count = live_count[CountW-1:0];
        r.table_full     = full;
        r.end_of_array   = it.is_last;
        if (it.is_last) begin
            foreach (slot_used[i]) slot_used[i] = 1'b0;
            live_count = 0;
        end
        return r;
    endfunction

    task automatic check_field(input string name, input logic [63:0] exp, input logic [63:0] act);
        if (exp !== act) begin
            $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, exp, act);
            errors++;
        end
    endtask

    // Sender: bursts of items with random gaps
    int unsigned burst_left = 0;
    int unsigned gap_left = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || !in_stall) begin
            if (gap_left > 0) begin
                gap_left--;
                in_valid <= 1'b0;
            end else if (feed_q.size() > 0) begin
                in_item  <= feed_q.pop_front();
                in_valid <= 1'b1;
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 24);
                    gap_left = (sender_gaps && $urandom_range(0, 3) != 0) ?
                               $urandom_range(1, 8) : 0;
                end else begin
                    burst_left--;
                end
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Receiver: stall pattern of its own, plus one long hold-off
    int unsigned hold_left = 0;
    int unsigned stall_pct = 30;
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left--;
            out_stall <= 1'b1;
        end else if (long_hold_req && !long_hold_done) begin
            long_hold_done = 1'b1;
            hold_left = LongHold;
            out_stall <= 1'b1;
        end else begin
            if ($urandom_range(0, 99) == 0) stall_pct = $urandom_range(0, 3) * 25;
            out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    // Monitor: predict on accepted inputs, check accepted results
    t_out_item want;
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CycleLimit) begin
            $display("Timeout after %0d cycles", cycles);
            $display("Some tests failed");
            $finish;
        end
        if (i_rst_n && in_valid && !in_stall) begin
            result_q.push_back(dedup_result(in_item));
            items_seen++;
        end
        if (i_rst_n && out_valid && !out_stall) begin
            if (result_q.size() == 0) begin
                $display("%0t ns: unexpected result, actual %h", $time, out_item);
                errors++;
            end else begin
                want = result_q.pop_front();
                check_field("first_seen", want.first_seen, out_item.first_seen);
                check_field("unique_low", want.unique_low, out_item.unique_low);
                check_field("unique_high", want.unique_high, out_item.unique_high);
                check_field("distinct_count", want.distinct_count, out_item.distinct_count);
                check_field("table_full", want.table_full, out_item.table_full);
                check_field("end_of_array", want.end_of_array, out_item.end_of_array);
                firsts_seen += out_item.first_seen;
                fulls_seen += out_item.table_full;
            end
        end
    end

    task automatic add_item(input logic [63:0] lo, input logic [63:0] hi, input bit last);
        t_in_item it;
        it.value_low = lo;
        it.value_high = hi;
        it.is_last = last;
        feed_q.push_back(it);
    endtask

    // Wait for the stream to drain, then for any clearing pass
    task automatic settle();
        while (feed_q.size() > 0 || in_valid || result_q.size() > 0) @(posedge i_clk);
        repeat (ClearWait) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [0:0] idx, input logic [31:0] val);
        @(posedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        paddr   <= idx;
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_KIND) cfg_kind = val[1:0];
        else cfg_nan_eq = val[0];
    endtask

    task automatic set_config(input logic [1:0] kind, input logic nan_eq);
        write_reg(REG_KIND, {30'd0, kind});
        write_reg(REG_NAN, {31'd0, nan_eq});
    endtask

    // One float part: half the draws are signed zeros, NaNs or infinities so NaN and zero rules get exercised
    function automatic logic [63:0] float_part(input bit wide);
        logic [63:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(0, 7))
            0: v = wide ? 64'h0 : 64'h0;
            1: v = wide ? 64'h8000000000000000 : 64'h80000000;
            2: v = wide ? {1'b0, 11'h7FF, v[51:0] | 52'h1}
                        : {32'd0, 1'b0, 8'hFF, v[22:0] | 23'h1};
            3: v = wide ? {v[63], 11'h7FF, 52'h0} : {32'd0, v[31], 8'hFF, 23'h0};
            4: v = wide ? 64'h3FF0000000000000 : 64'h3F800000;
            default: v = wide ? v : {32'd0, v[31:0]};
        endcase
        return v;
    endfunction

    // Random arrays: values drawn from a small pool so repeats are common
    task automatic random_arrays(input int unsigned total);
        logic [63:0] pool_lo [8];
        logic [63:0] pool_hi [8];
        logic [63:0] f_re;
        logic [63:0] f_im;
        int unsigned left;
        int unsigned len;
        int unsigned p;
        left = total;
        while (left > 0) begin
            for (int i = 0; i < 8; i++) begin
                case (eff_kind())
                    KIND_C64: begin
                        f_re = float_part(0);
                        f_im = float_part(0);
                        pool_lo[i] = {f_im[31:0], f_re[31:0]};
                    end
                    KIND_C128: pool_lo[i] = float_part(1);
                    default:   pool_lo[i] = {$urandom, $urandom};
                endcase
                pool_hi[i] = (eff_kind() == KIND_C128) ? float_part(1) : {$urandom, $urandom};
            end
            len = $urandom_range(1, 40);
            if (len > left) len = left;
            for (int i = 0; i < len; i++) begin
                p = $urandom_range(0, 7);
                if ($urandom_range(0, 4) == 0) begin
                    add_item({$urandom, $urandom}, {$urandom, $urandom}, i == len - 1);
                end else begin
                    // bits outside the key must not matter
                    add_item(pool_lo[p], (eff_kind() == KIND_C128) ? pool_hi[p] :
                             {$urandom, $urandom}, i == len - 1);
                end
            end
            left -= len;
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        foreach (slot_used[i]) slot_used[i] = 1'b0;
        live_count = 0;

        // Directed: integer extremes and repeats at reset settings
        add_item(64'h0, 64'h0, 0);
        add_item(64'hFFFFFFFFFFFFFFFF, 64'hFFFFFFFFFFFFFFFF, 0);
        add_item(64'h0, 64'hFFFFFFFFFFFFFFFF, 0);
        add_item(64'hFFFFFFFFFFFFFFFF, 64'h0, 1);
        settle();
        // complex64: signed zeros, NaNs equal, infinity
        set_config(KIND_C64, 1'b1);
        add_item(64'h0000000080000000, 64'h0, 0);
        add_item(64'h8000000000000000, 64'h1, 0);
        add_item(64'h7FC00000FF800001, 64'h0, 0);
        add_item(64'h000000007F800001, 64'h0, 0);
        add_item(64'h7F80000000000000, 64'h0, 1);
        settle();
        // complex128 with NaNs never matching
        set_config(KIND_C128, 1'b0);
        add_item(64'h8000000000000000, 64'h0, 0);
        add_item(64'h0, 64'h8000000000000000, 0);
        add_item(64'h7FF0000000000001, 64'h0, 0);
        add_item(64'h7FF0000000000001, 64'h0, 0);
        add_item(64'h0, 64'hFFFFFFFFFFFFFFFF, 0);
        add_item(64'hFFF0000000000000, 64'h7FF0000000000000, 1);
        settle();
        // unused kind code acts as integer; complex128 NaNs merged
        set_config(KIND_RSVD, 1'b1);
        add_item(64'h8000000000000000, 64'h0, 0);
        add_item(64'h0, 64'h5, 0);
        add_item(64'h8000000000000000, 64'h9, 1);
        settle();
        set_config(KIND_C128, 1'b1);
        add_item(64'h7FF8000000000000, 64'h0, 0);
        add_item(64'h0, 64'hFFFFFFFFFFFFFFFF, 0);
        add_item(64'h1, 64'h2, 1);
        settle();

        // Fill the table completely, then overflow it
        set_config(KIND_INT, 1'b0);
        for (int i = 0; i < Slots + 6; i++) begin
            add_item({$urandom, 16'($urandom_range(0, 65535)), i[15:0]}, 64'h0, 0);
        end
        add_item(64'h0, 64'h0, 0);
        add_item(64'h1234, 64'h0, 1);
        settle();

        // Random arrays under each setting, with one long receiver hold
        set_config(KIND_INT, 1'b1);
        sender_gaps = 1'b0;
        long_hold_req = 1'b1;
        random_arrays(130);
        settle();
        sender_gaps = 1'b1;
        set_config(KIND_C64, 1'b1);
        random_arrays(130);
        settle();
        set_config(KIND_C64, 1'b0);
        random_arrays(130);
        settle();
        set_config(KIND_C128, 1'b0);
        random_arrays(130);
        settle();
        set_config(KIND_C128, 1'b1);
        random_arrays(130);
        settle();
        set_config(KIND_RSVD, 1'b0);
        random_arrays(100);
        settle();

        $display("Run covered %0d items over all kinds and NaN policies:", items_seen);
        $display("  %0d first seen, %0d overflow.", firsts_seen, fulls_seen);
        if (errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule
